@@ src/bta_pkg.sv @@
// shared constants and types for the boundary tag heap allocator
`default_nettype none
package bta_pkg;

  localparam int unsigned HEAP_BYTES_DEF    = 32768;
  localparam int unsigned GRANULE_BYTES_DEF = 16;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOS  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_F_RH,
    ST_F_CH,
    ST_F_RF,
    ST_F_CF,
    ST_F_RP,
    ST_F_CP,
    ST_F_RN,
    ST_F_CN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ src/bta_tag_ram.sv @@
// tag memory, one write port and one registered read port
`default_nettype none
module bta_tag_ram #(
  parameter int unsigned AW = 11,
  parameter int unsigned DW = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/boundary_tag_heap_allocator_top.sv @@
// top level of the boundary tag heap allocator
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tuser: func; tdata: request_bytes, block_addr
// out_     out  out_tvalid/out_tready  tuser: status; tdata: payload_addr
//
// after reset the tag memory is cleared, one entry a cycle, all HEAP_BYTES/GRANULE_BYTES
// entries (2048 by default), while in_tready stays low
// allocate: reads block headers in turn, writes the granted tags, then posts
// free: reads block and neighbour tags, writes merged tags if released, then posts
// one item at a time; a held result stalls only the posting of the next one
`default_nettype none
module boundary_tag_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES    = bta_pkg::HEAP_BYTES_DEF,
  parameter int unsigned GRANULE_BYTES = bta_pkg::GRANULE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // request_bytes[14:0], block_addr[29:15], zeros
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // payload_addr[14:0], zero
  output logic             out_tuser   // status
);
  import bta_pkg::*;

  localparam int unsigned NGRAN = HEAP_BYTES / GRANULE_BYTES;
  localparam int unsigned GW    = $clog2(NGRAN);
  localparam int unsigned SW    = GW + 1;
  localparam int unsigned TW    = SW + 2;
  localparam int unsigned LG    = $clog2(GRANULE_BYTES);
  localparam int unsigned NW    = 17 - LG;
  localparam int unsigned CW    = (SW > NW) ? SW : NW;
  localparam logic [SW-1:0] NG  = SW'(NGRAN);
  localparam logic [SW-1:0] TWO = SW'(2);

  state_t state_r, state_nxt;

  logic [GW-1:0] clr_cnt_r;
  logic          func_r;
  logic [NW-1:0] need_r;
  logic [SW-1:0] h_r, n_r, m_r, start_r, total_r, nd_r;
  logic          lo_r, hi_r, split_r, fail_r;
  logic [2:0]    step_r;
  logic          out_valid_r, out_status_r;
  logic [14:0]   out_addr_r;

  logic          we;
  logic [GW-1:0] waddr, raddr;
  logic [TW-1:0] wdata, rdata;
  logic [SW-1:0] rd_size;
  logic          rd_head, rd_alloc;

  logic          in_xfer, post_ok;
  logic [14:0]   req_bytes, blk_addr;
  logic [16:0]   need_sum;
  logic [14:0]   blk_gran;
  logic          blk_bad;
  logic [SW-1:0] sa, a_end, f_end, hn;
  logic [CW-1:0] n_ext, need_ext;
  logic [31:0]   grant_w;

  assign rd_size  = rdata[TW-1:2];
  assign rd_head  = rdata[1];
  assign rd_alloc = rdata[0];

  assign req_bytes = in_tdata[14:0];
  assign blk_addr  = in_tdata[29:15];
  assign need_sum  = 17'(req_bytes) + 17'(3 * GRANULE_BYTES - 1);
  assign blk_gran  = blk_addr >> LG;
  assign blk_bad   = (blk_addr[LG-1:0] != '0) || (blk_gran == '0) || (32'(blk_gran) > NGRAN);

  assign in_xfer = in_tvalid && in_tready;
  assign post_ok = !out_valid_r || out_tready;

  assign n_ext    = CW'(rd_size);
  assign need_ext = CW'(need_r);
  assign hn       = h_r + n_r;
  assign sa       = split_r ? nd_r : n_r;
  assign a_end    = h_r + sa - SW'(1);
  assign f_end    = start_r + total_r - SW'(1);
  assign grant_w  = (32'(h_r) + 32'd1) << LG;

  bta_tag_ram #(.AW(GW), .DW(TW)) u_tag_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == GW'(NGRAN - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == FUNC_ALLOC) state_nxt = ST_A_RD;
          else if (blk_bad)           state_nxt = ST_DONE;
          else                        state_nxt = ST_F_RH;
        end
      end
      ST_A_RD: state_nxt = ST_A_CHK;
      ST_A_CHK: begin
        if (h_r >= NG || !rd_head || rd_size < TWO || rd_size > NG - h_r) begin
          state_nxt = ST_DONE;
        end else if (!rd_alloc && n_ext >= need_ext) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_A_RD;
        end
      end
      ST_F_RH: state_nxt = ST_F_CH;
      ST_F_CH: begin
        if (!rd_head || !rd_alloc || rd_size < TWO || rd_size > NG - h_r) state_nxt = ST_DONE;
        else if (h_r != '0)                                             state_nxt = ST_F_RF;
        else if (h_r + rd_size < NG)                                    state_nxt = ST_F_RN;
        else                                                            state_nxt = ST_WRITE;
      end
      ST_F_RF: state_nxt = ST_F_CF;
      ST_F_CF: begin
        if (rd_size >= TWO && rd_size <= h_r && !rd_alloc) state_nxt = ST_F_RP;
        else if (hn < NG)                                   state_nxt = ST_F_RN;
        else                                                state_nxt = ST_WRITE;
      end
      ST_F_RP: state_nxt = ST_F_CP;
      ST_F_CP: state_nxt = (hn < NG) ? ST_F_RN : ST_WRITE;
      ST_F_RN: state_nxt = ST_F_CN;
      ST_F_CN: state_nxt = ST_WRITE;
      ST_WRITE: if (step_r == 3'd5) state_nxt = ST_DONE;
      ST_DONE: if (post_ok) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    raddr     = h_r[GW-1:0];
    we        = 1'b0;
    waddr     = clr_cnt_r;
    wdata     = '0;
    case (state_r)
      ST_F_RF: raddr = GW'(h_r - SW'(1));
      ST_F_RP: raddr = GW'(h_r - m_r);
      ST_F_RN: raddr = GW'(hn);
      ST_CLEAR: begin
        we = 1'b1;
        if (clr_cnt_r == '0)                    wdata = {NG, 1'b1, 1'b0};
        else if (clr_cnt_r == GW'(NGRAN - 1))   wdata = {NG, 1'b0, 1'b0};
      end
      ST_WRITE: begin
        if (func_r == FUNC_ALLOC) begin
          case (step_r)
            3'd0: begin we = 1'b1; waddr = GW'(h_r);   wdata = {sa, 1'b1, 1'b1}; end
            3'd1: begin we = 1'b1; waddr = GW'(a_end); wdata = {sa, 1'b0, 1'b1}; end
            3'd2: begin
              we = split_r; waddr = GW'(h_r + nd_r); wdata = {n_r - nd_r, 1'b1, 1'b0};
            end
            3'd3: begin
              we = split_r; waddr = GW'(hn - SW'(1)); wdata = {n_r - nd_r, 1'b0, 1'b0};
            end
            default: we = 1'b0;
          endcase
        end else begin
          case (step_r)
            3'd0: begin we = lo_r; waddr = GW'(h_r - SW'(1)); end
            3'd1: begin we = lo_r; waddr = GW'(h_r); end
            3'd2: begin we = hi_r; waddr = GW'(hn - SW'(1)); end
            3'd3: begin we = hi_r; waddr = GW'(hn); end
            3'd4: begin we = 1'b1; waddr = GW'(start_r); wdata = {total_r, 1'b1, 1'b0}; end
            3'd5: begin we = 1'b1; waddr = GW'(f_end);   wdata = {total_r, 1'b0, 1'b0}; end
            default: we = 1'b0;
          endcase
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready && !(state_r == ST_DONE && post_ok)) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: clr_cnt_r <= clr_cnt_r + GW'(1);
        ST_IDLE: begin
          if (in_xfer) begin
            func_r  <= in_tuser;
            need_r  <= NW'(need_sum >> LG);
            h_r     <= (in_tuser == FUNC_ALLOC) ? '0 : SW'(blk_gran - 15'd1);
            lo_r    <= 1'b0;
            hi_r    <= 1'b0;
            split_r <= 1'b0;
            fail_r  <= 1'b0;
            step_r  <= '0;
          end
        end
        ST_A_CHK: begin
          if (h_r >= NG || !rd_head || rd_size < TWO || rd_size > NG - h_r) begin
            fail_r <= 1'b1;
          end else if (!rd_alloc && n_ext >= need_ext) begin
            n_r     <= rd_size;
            nd_r    <= SW'(need_r);
            split_r <= (n_ext - need_ext) >= CW'(2);
          end else begin
            h_r <= h_r + rd_size;
          end
        end
        ST_F_CH: begin
          n_r     <= rd_size;
          total_r <= rd_size;
          start_r <= h_r;
        end
        ST_F_CF: m_r <= rd_size;
        ST_F_CP: begin
          if (rd_head && !rd_alloc) begin
            lo_r    <= 1'b1;
            start_r <= h_r - m_r;
            total_r <= total_r + m_r;
          end
        end
        ST_F_CN: begin
          if (rd_head && !rd_alloc && rd_size >= TWO && rd_size <= NG - hn) begin
            hi_r    <= 1'b1;
            total_r <= total_r + rd_size;
          end
        end
        ST_WRITE: step_r <= step_r + 3'd1;
        ST_DONE: begin
          if (post_ok) begin
            out_valid_r <= 1'b1;
            if (func_r == FUNC_ALLOC && !fail_r) begin
              out_addr_r   <= grant_w[14:0];
              out_status_r <= STATUS_DONE;
            end else begin
              out_addr_r   <= '0;
              out_status_r <= (func_r == FUNC_ALLOC) ? STATUS_OOS : STATUS_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_addr_r};
  assign out_tuser  = out_status_r;

  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == ST_CLEAR || state_r == ST_WRITE))
    else $error("tag write outside clear or write phase");

  a_post: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && post_ok) |=> out_tvalid)
    else $error("result not posted");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("second transfer taken before result");

endmodule
`default_nettype wire
